// ===== sv/cfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared constants, types and codes of the conjunctive feature evaluator.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int MAX_FEATURES      = 32;
    localparam int CONDS_PER_FEATURE = 8;
    localparam int NUM_ATTRS         = 64;
    localparam int VALUE_WIDTH       = 32;

    // numeric compare width, capped at the 32-bit field width
    localparam int VAL_W      = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int SLOT_TOTAL = MAX_FEATURES * CONDS_PER_FEATURE;
    localparam int ADDR_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int FEAT_W     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SLOT_W     = (CONDS_PER_FEATURE > 1) ? $clog2(CONDS_PER_FEATURE) : 1;
    localparam int ATTR_AW    = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
    localparam int CNT_W      = 7;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_EVAL  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        KIND_EMPTY    = 2'd0,
        KIND_CAT      = 2'd1,
        KIND_INTERVAL = 2'd2,
        KIND_MISSING  = 2'd3
    } cond_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } fsm_t;

    typedef struct packed {
        cond_kind_t  kind;
        logic [5:0]  attr;
        logic [7:0]  cat;
    } cond_head_t;

    typedef struct packed {
        cond_head_t         head;
        logic signed [31:0] upper;
        logic signed [31:0] lower;
    } cond_t;

    typedef struct packed {
        logic               missing;
        logic signed [31:0] num;
        logic [7:0]         cat;
    } attr_t;

endpackage

// ===== sv/conjunctive_feature_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// conjunctive_feature_evaluator_unit
// Load, attribute write and evaluate control around the condition and
// attribute memories; one result per feature through an output register.
// ----------------------------------------------------------------------------
// Load and write requests are handled in the idle state.
// Evaluate: one condition-memory read per cycle for each slot of a feature,
//   then the head/attribute read chain drains before the feature's result
//   enters the output register, which may wait on an output stall.
// Reset: slot valid bits cleared (all slots empty), feature_count 0,
//   no clearing pass; in_ready is already high when reset is released.
module conjunctive_feature_evaluator_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [5:0]   cfg_wr_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   func,
    input  logic [4:0]   feature_index,
    input  logic [2:0]   cond_slot,
    input  logic [1:0]   cond_kind,
    input  logic [5:0]   attr_index,
    input  logic [7:0]   cat_value,
    input  logic signed [31:0] num_value,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic         missing_flag,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [4:0]   out_feature,
    output logic         feature_bit,
    output logic         last_feature
);
    import cfe_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CONDS_PER_FEATURE - 1);

    fsm_t                state_reg, state_next;
    logic [5:0]          feature_count_reg;
    logic [CNT_W-1:0]    n_sat;
    logic [FEAT_W-1:0]   feat_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                acc_reg;
    logic                out_valid_reg;
    logic [4:0]          out_feature_reg;
    logic                feature_bit_reg;
    logic                last_feature_reg;

    logic                req_acc;
    logic                load_en;
    logic                write_en;
    logic                eval_start;
    logic                issue;
    logic                load_out;
    logic                is_last;
    logic                rd_vld;
    cond_t               rd_cond;
    cond_t               wr_cond;
    attr_t               wr_attr;
    logic                res_vld;
    logic                res_hold;

    assign req_acc  = in_valid && in_ready;
    assign load_en  = req_acc && (func_t'(func) == FUNC_LOAD) &&
                      (int'(feature_index) < MAX_FEATURES) &&
                      (int'(cond_slot) < CONDS_PER_FEATURE);
    assign write_en = req_acc && (func_t'(func) == FUNC_WRITE) &&
                      (int'(attr_index) < NUM_ATTRS);

    assign n_sat = (int'(feature_count_reg) > MAX_FEATURES) ? CNT_W'(MAX_FEATURES)
                                                            : CNT_W'(feature_count_reg);
    assign eval_start = req_acc && (func_t'(func) == FUNC_EVAL) && (n_sat != '0);
    assign is_last    = ((CNT_W'(feat_reg) + CNT_W'(1)) == n_sat);

    always_comb
    begin
        wr_cond.head.kind = cond_kind_t'(cond_kind);
        wr_cond.head.attr = attr_index;
        wr_cond.head.cat  = cat_value;
        wr_cond.upper     = upper_bound;
        wr_cond.lower     = lower_bound;
        wr_attr.missing   = missing_flag;
        wr_attr.num       = num_value;
        wr_attr.cat       = cat_value;
    end

    cfe_cond_store u_cond_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_addr (ADDR_W'(int'(feature_index) * CONDS_PER_FEATURE + int'(cond_slot))),
        .wr_cond (wr_cond),
        .rd_en   (issue),
        .rd_addr (addr_reg),
        .rd_vld  (rd_vld),
        .rd_cond (rd_cond)
    );

    cfe_slot_eval u_slot_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .attr_we    (write_en),
        .attr_waddr (ATTR_AW'(attr_index)),
        .attr_wdata (wr_attr),
        .s1_vld     (rd_vld),
        .s1_cond    (rd_cond),
        .res_vld    (res_vld),
        .res_hold   (res_hold)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (eval_start)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld && !res_vld)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = is_last ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg <= '0;
            feat_reg          <= '0;
            slot_reg          <= '0;
            addr_reg          <= '0;
            acc_reg           <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                feature_count_reg <= cfg_wr_data;
            end

            if (eval_start)
            begin
                feat_reg <= '0;
                slot_reg <= '0;
                addr_reg <= '0;
                acc_reg  <= 1'b1;
            end
            else
            begin
                if (issue)
                begin
                    slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                    addr_reg <= addr_reg + ADDR_W'(1);
                end
                // any failing slot clears the feature
                if (res_vld && !res_hold)
                begin
                    acc_reg <= 1'b0;
                end
                if (load_out && !is_last)
                begin
                    feat_reg <= feat_reg + FEAT_W'(1);
                    acc_reg  <= 1'b1;
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_feature_reg  <= 5'(feat_reg);
            feature_bit_reg  <= acc_reg;
            last_feature_reg <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_feature  = out_feature_reg;
    assign feature_bit  = feature_bit_reg;
    assign last_feature = last_feature_reg;

endmodule

// ===== sv/cfe_ram.sv =====
// ----------------------------------------------------------------------------
// cfe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cfe_cond_store.sv =====
// ----------------------------------------------------------------------------
// cfe_cond_store
// Condition slot memories (head and bounds) with per-slot valid bits.
// ----------------------------------------------------------------------------
module cfe_cond_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [cfe_pkg::ADDR_W-1:0] wr_addr,
    input  cfe_pkg::cond_t             wr_cond,
    input  logic                       rd_en,
    input  logic [cfe_pkg::ADDR_W-1:0] rd_addr,
    output logic                       rd_vld,
    output cfe_pkg::cond_t             rd_cond
);
    import cfe_pkg::*;

    logic [SLOT_TOTAL-1:0] hvalid_reg;
    logic                  rd_vld_reg;
    logic                  rd_hv_reg;
    logic [15:0]           head_q;
    logic [63:0]           bound_q;
    cond_head_t            head_s;

    cfe_ram #(.WIDTH(16), .DEPTH(SLOT_TOTAL)) u_head_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_cond.head),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (head_q)
    );

    cfe_ram #(.WIDTH(64), .DEPTH(SLOT_TOTAL)) u_bound_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({wr_cond.upper, wr_cond.lower}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (bound_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            rd_vld_reg <= 1'b0;
            rd_hv_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                hvalid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= rd_en;
            if (rd_en)
            begin
                rd_hv_reg <= hvalid_reg[rd_addr];
            end
        end
    end

    // never-loaded slots read as empty
    always_comb
    begin
        head_s = cond_head_t'(head_q);
        if (!rd_hv_reg)
        begin
            head_s.kind = KIND_EMPTY;
        end
        rd_cond.head  = head_s;
        rd_cond.upper = bound_q[63:32];
        rd_cond.lower = bound_q[31:0];
    end

    assign rd_vld = rd_vld_reg;

endmodule

// ===== sv/cfe_slot_eval.sv =====
// ----------------------------------------------------------------------------
// cfe_slot_eval
// Instance attribute memory and the per-slot condition test.
// ----------------------------------------------------------------------------
module cfe_slot_eval (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        attr_we,
    input  logic [cfe_pkg::ATTR_AW-1:0] attr_waddr,
    input  cfe_pkg::attr_t              attr_wdata,
    input  logic                        s1_vld,
    input  cfe_pkg::cond_t              s1_cond,
    output logic                        res_vld,
    output logic                        res_hold
);
    import cfe_pkg::*;

    logic [$bits(attr_t)-1:0] attr_raw;
    attr_t                    attr_q;
    cond_t                    s2_cond_reg;
    logic                     s2_vld_reg;
    logic                     attr_ok_reg;
    logic signed [VAL_W-1:0]  num_v;
    logic signed [VAL_W-1:0]  lo_v;
    logic signed [VAL_W-1:0]  up_v;
    logic                     in_range;

    cfe_ram #(.WIDTH($bits(attr_t)), .DEPTH(NUM_ATTRS)) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (attr_waddr),
        .wdata (attr_wdata),
        .re    (s1_vld),
        .raddr (ATTR_AW'(s1_cond.head.attr)),
        .rdata (attr_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld)
        begin
            s2_cond_reg <= s1_cond;
            attr_ok_reg <= (int'(s1_cond.head.attr) < NUM_ATTRS);
        end
    end

    assign attr_q = attr_t'(attr_raw);
    assign num_v  = attr_q.num[VAL_W-1:0];
    assign lo_v   = s2_cond_reg.lower[VAL_W-1:0];
    assign up_v   = s2_cond_reg.upper[VAL_W-1:0];

    // upper bound at the largest value means no upper limit
    assign in_range = (num_v >= lo_v) &&
                      ((s2_cond_reg.upper[VAL_W-1:0] == VAL_MAX) || (num_v < up_v));

    always_comb
    begin
        res_hold = 1'b0;
        if (s2_cond_reg.head.kind == KIND_EMPTY)
        begin
            res_hold = 1'b1;
        end
        else if (attr_ok_reg)
        begin
            unique case (s2_cond_reg.head.kind)
                KIND_CAT:      res_hold = (attr_q.cat == s2_cond_reg.head.cat);
                KIND_INTERVAL: res_hold = !attr_q.missing && in_range;
                KIND_MISSING:  res_hold = attr_q.missing;
                default:       res_hold = 1'b1;
            endcase
        end
    end

    assign res_vld = s2_vld_reg;

endmodule

// ===== sv/cfe_checker.sv =====
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks of the result channel and of run sequencing.
// ----------------------------------------------------------------------------
module cfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] out_feature,
    input logic       feature_bit,
    input logic       last_feature
);

    logic [4:0] exp_feature_reg;

    // next feature index expected on the result channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_feature_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_feature_reg <= last_feature ? 5'd0 : out_feature + 5'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_feature) && $stable(feature_bit) &&
                                   $stable(last_feature))
        else $error("result changed while stalled");

    a_no_req_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_feature |-> !in_ready)
        else $error("request taken during an evaluate run");

    a_feature_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_feature == exp_feature_reg)
        else $error("feature results out of order");

endmodule

bind conjunctive_feature_evaluator_unit cfe_checker u_cfe_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for conjunctive_feature_evaluator_unit. Drives load, attribute
// write and evaluate requests through a valid/ready port, with random idle
// bursts on both sides. It keeps its own copy of the condition slots, the
// instance and feature_count, predicts every feature result and checks each
// one against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import cfe_pkg::*;

    localparam logic [1:0]         FUNC_NONE      = 2'd3;  // unassigned code, dropped
    localparam logic signed [31:0] Q_MIN          = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX          = VAL_MAX;
    localparam int                 SETTLE_CYCLES  = 20;
    localparam int                 WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [1:0]         op;
        logic [4:0]         feat;
        logic [2:0]         slot;
        logic [1:0]         kind;
        logic [5:0]         attr;
        logic [7:0]         cat;
        logic signed [31:0] num;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic               miss;
    } request_t;

    typedef struct {
        logic [4:0] feat;
        logic       hit;
        logic       last;
    } feature_result_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [5:0]         cfg_wr_data   = '0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [1:0]         func          = '0;
    logic [4:0]         feature_index = '0;
    logic [2:0]         cond_slot     = '0;
    logic [1:0]         cond_kind     = '0;
    logic [5:0]         attr_index    = '0;
    logic [7:0]         cat_value     = '0;
    logic signed [31:0] num_value     = '0;
    logic signed [31:0] lower_bound   = '0;
    logic signed [31:0] upper_bound   = '0;
    logic               missing_flag  = 1'b0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [4:0]         out_feature;
    logic               feature_bit;
    logic               last_feature;

    // predicted block state
    cond_kind_t         slot_kind  [SLOT_TOTAL];
    logic [5:0]         slot_attr  [SLOT_TOTAL];
    logic [7:0]         slot_cat   [SLOT_TOTAL];
    logic signed [31:0] slot_lower [SLOT_TOTAL];
    logic signed [31:0] slot_upper [SLOT_TOTAL];
    logic [7:0]         inst_cat     [NUM_ATTRS];
    logic signed [31:0] inst_num     [NUM_ATTRS];
    logic               inst_missing [NUM_ATTRS];
    logic [5:0]         feature_count_reg = '0;

    feature_result_t    expected_bits_q[$];

    bit idle_enable     = 1'b1;
    int ready_hold      = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int load_count      = 0;
    int write_count     = 0;
    int eval_count      = 0;
    int other_count     = 0;

    conjunctive_feature_evaluator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .feature_index (feature_index),
        .cond_slot     (cond_slot),
        .cond_kind     (cond_kind),
        .attr_index    (attr_index),
        .cat_value     (cat_value),
        .num_value     (num_value),
        .lower_bound   (lower_bound),
        .upper_bound   (upper_bound),
        .missing_flag  (missing_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_feature   (out_feature),
        .feature_bit   (feature_bit),
        .last_feature  (last_feature)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic slot_holds(input int idx);
        int a;
        a = int'(slot_attr[idx]);  // 6-bit index, always inside the instance
        case (slot_kind[idx])
            KIND_EMPTY:
                return 1'b1;
            KIND_CAT:
                return inst_cat[a] == slot_cat[idx];
            KIND_INTERVAL:
            begin
                if (inst_missing[a])
                    return 1'b0;
                if (inst_num[a] < slot_lower[idx])
                    return 1'b0;
                // largest value as upper bound means no upper limit
                if (slot_upper[idx] != Q_MAX && inst_num[a] >= slot_upper[idx])
                    return 1'b0;
                return 1'b1;
            end
            default:
                return inst_missing[a];
        endcase
    endfunction

    function automatic logic feature_holds(input int f);
        for (int s = 0; s < CONDS_PER_FEATURE; s++)
            if (!slot_holds(f * CONDS_PER_FEATURE + s))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_feature_bits(input request_t r);
        int              idx;
        int              n;
        feature_result_t res;
        case (r.op)
            FUNC_LOAD:
            begin
                idx = r.feat * CONDS_PER_FEATURE + r.slot;
                slot_kind[idx]  = cond_kind_t'(r.kind);
                slot_attr[idx]  = r.attr;
                slot_cat[idx]   = r.cat;
                slot_lower[idx] = r.lower;
                slot_upper[idx] = r.upper;
            end
            FUNC_WRITE:
            begin
                inst_cat[r.attr]     = r.cat;
                inst_num[r.attr]     = r.num;
                inst_missing[r.attr] = r.miss;
            end
            FUNC_EVAL:
            begin
                n = (feature_count_reg > MAX_FEATURES) ? MAX_FEATURES : feature_count_reg;
                for (int f = 0; f < n; f++)
                begin
                    res.feat = f[4:0];
                    res.hit  = feature_holds(f);
                    res.last = (f == n - 1);
                    expected_bits_q = {expected_bits_q, res};
                end
            end
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic request_t noise_request();
        request_t r;
        r.op    = 2'($urandom_range(0, 3));
        r.feat  = 5'($urandom_range(0, 31));
        r.slot  = 3'($urandom_range(0, 7));
        r.kind  = 2'($urandom_range(0, 3));
        r.attr  = 6'($urandom_range(0, 63));
        r.cat   = 8'($urandom_range(0, 255));
        r.num   = $urandom();
        r.lower = $urandom();
        r.upper = $urandom();
        r.miss  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[31:0];
    endfunction

    task automatic send_request(input request_t r);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= r.op;
        feature_index <= r.feat;
        cond_slot     <= r.slot;
        cond_kind     <= r.kind;
        attr_index    <= r.attr;
        cat_value     <= r.cat;
        num_value     <= r.num;
        lower_bound   <= r.lower;
        upper_bound   <= r.upper;
        missing_flag  <= r.miss;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_feature_bits(r);
        case (r.op)
            FUNC_LOAD:  load_count++;
            FUNC_WRITE: write_count++;
            FUNC_EVAL:  eval_count++;
            default:    other_count++;
        endcase
    endtask

    task automatic load_slot(input int feat, input int slot, input cond_kind_t kind,
                             input int attr, input logic [7:0] cat,
                             input logic signed [31:0] lo, input logic signed [31:0] hi);
        request_t r;
        r       = noise_request();
        r.op    = FUNC_LOAD;
        r.feat  = 5'(feat);
        r.slot  = 3'(slot);
        r.kind  = kind;
        r.attr  = 6'(attr);
        r.cat   = cat;
        r.lower = lo;
        r.upper = hi;
        send_request(r);
    endtask

    task automatic write_attr(input int attr, input logic [7:0] cat,
                              input logic signed [31:0] num, input logic miss);
        request_t r;
        r      = noise_request();
        r.op   = FUNC_WRITE;
        r.attr = 6'(attr);
        r.cat  = cat;
        r.num  = num;
        r.miss = miss;
        send_request(r);
    endtask

    task automatic evaluate_all();
        request_t r;
        r    = noise_request();
        r.op = FUNC_EVAL;
        send_request(r);
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_bits_q.size() != 0)
            @(posedge clk);
        // loads and dropped requests leave nothing to wait for
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_feature_count(input logic [5:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en         <= 1'b0;
        feature_count_reg = value;
    endtask

    // slot that mostly holds against the current instance
    function automatic request_t random_load();
        request_t r;
        int       sel;
        r    = noise_request();
        r.op = FUNC_LOAD;
        sel  = $urandom_range(0, 9);
        r.kind = (sel < 3) ? KIND_EMPTY : (sel < 6) ? KIND_CAT :
                 (sel < 9) ? KIND_INTERVAL : KIND_MISSING;
        if ($urandom_range(0, 3) != 0)
        begin
            r.cat   = inst_cat[r.attr];
            r.lower = ($urandom_range(0, 3) == 0) ? Q_MIN :
                      clamp_q16(longint'(inst_num[r.attr])
                                - longint'($urandom_range(0, 100000)));
            r.upper = ($urandom_range(0, 3) == 0) ? Q_MAX :
                      clamp_q16(longint'(inst_num[r.attr]) + 1
                                + longint'($urandom_range(0, 100000)));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (out_ready && idle_enable)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 9);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 40);
        end
    end

    always @(posedge clk)
    begin : result_check
        feature_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_bits_q.size() == 0)
            begin
                $display("%0t: result with no request pending: feature %0d bit %0d last %0d",
                         $time, out_feature, feature_bit, last_feature);
                mismatch_count++;
            end
            else
            begin
                want = expected_bits_q.pop_front();
                results_checked++;
                if (out_feature !== want.feat)
                begin
                    $display("%0t: out_feature expected %0d actual %0d",
                             $time, want.feat, out_feature);
                    mismatch_count++;
                end
                if (feature_bit !== want.hit)
                begin
                    $display("%0t: feature_bit of feature %0d expected %0d actual %0d",
                             $time, want.feat, want.hit, feature_bit);
                    mismatch_count++;
                end
                if (last_feature !== want.last)
                begin
                    $display("%0t: last_feature of feature %0d expected %0d actual %0d",
                             $time, want.feat, want.last, last_feature);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request or result moved for %0d cycles, %0d results pending",
                 $time, WATCHDOG_LIMIT, expected_bits_q.size());
        $display("conjunctive_feature_evaluator_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // feature_count is 0 out of reset; unknown code is dropped; then every
    // feature is still all-empty and must read as 1
    task automatic test_reset_state();
        request_t r;
        evaluate_all();
        r    = noise_request();
        r.op = FUNC_NONE;
        send_request(r);
        wait_for_idle();
        write_feature_count(6'd32);
        evaluate_all();
        wait_for_idle();
    endtask

    // fill the whole instance so no condition ever reads an unwritten attribute
    task automatic test_instance_load();
        for (int a = 0; a < NUM_ATTRS; a++)
        begin
            case (a)
                0:       write_attr(a, 8'h00, Q_MIN, 1'b0);
                20:      write_attr(a, 8'h5A, 32'sh0001_8000, 1'b0);
                63:      write_attr(a, 8'hFF, Q_MAX, 1'b0);
                default: write_attr(a, 8'($urandom_range(0, 255)), $urandom(),
                                    (a % 8) == 5);
            endcase
        end
        wait_for_idle();
    endtask

    task automatic test_condition_kinds();
        write_feature_count(6'd63);  // saturates to all features
        load_slot(1, 0, KIND_CAT, 20, 8'h5A, $urandom(), $urandom());
        load_slot(2, 7, KIND_CAT, 20, 8'hA5, $urandom(), $urandom());
        load_slot(3, 0, KIND_INTERVAL, 10, 8'($urandom_range(0, 255)), Q_MIN, Q_MAX);
        // value on the lower bound holds, on the upper bound fails
        load_slot(4, 1, KIND_INTERVAL, 20, 8'h00, 32'sh0001_8000, 32'sh0001_8001);
        load_slot(5, 2, KIND_INTERVAL, 20, 8'h00, 32'sh0001_0000, 32'sh0001_8000);
        // interval on a missing attribute never holds
        load_slot(6, 0, KIND_INTERVAL, 5, 8'h00, Q_MIN, Q_MAX);
        load_slot(7, 0, KIND_MISSING, 5, 8'h00, $urandom(), $urandom());
        load_slot(8, 0, KIND_MISSING, 10, 8'h00, $urandom(), $urandom());
        load_slot(9, 0, KIND_CAT, 20, 8'h5A, $urandom(), $urandom());
        load_slot(9, 1, KIND_INTERVAL, 20, 8'h00, Q_MIN, 32'sh0002_0000);
        load_slot(9, 3, KIND_CAT, 20, 8'h00, $urandom(), $urandom());
        load_slot(9, 3, KIND_EMPTY, 63, 8'hFF, $urandom(), $urandom());  // clears it
        load_slot(10, 4, KIND_INTERVAL, 63, 8'h00, 32'sh0000_0000, Q_MAX);
        load_slot(11, 5, KIND_INTERVAL, 0, 8'h00, Q_MIN, 32'sh0000_0000);
        load_slot(12, 6, KIND_INTERVAL, 20, 8'h00, 32'sh0002_0000, 32'sh0001_0000);
        load_slot(31, 7, KIND_CAT, 63, 8'hFF, $urandom(), $urandom());
        evaluate_all();
        wait_for_idle();
    endtask

    task automatic test_feature_count_extremes();
        write_feature_count(6'd0);
        evaluate_all();
        wait_for_idle();
        write_feature_count(6'd1);
        evaluate_all();
        wait_for_idle();
        write_feature_count(6'd33);
        evaluate_all();
        wait_for_idle();
    endtask

    task automatic test_random_traffic(input logic [5:0] count, input int n_items,
                                       input bit with_idle);
        request_t r;
        int       pick;
        idle_enable = with_idle;
        write_feature_count(count);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_request(random_load());
            else if (pick < 85)
            begin
                r    = noise_request();
                r.op = FUNC_WRITE;
                if ($urandom_range(0, 1) == 1)
                    r.cat = 8'($urandom_range(0, 3));
                r.miss = ($urandom_range(0, 7) == 0);
                send_request(r);
            end
            else if (pick < 95)
                evaluate_all();
            else
            begin
                r    = noise_request();
                r.op = FUNC_NONE;
                send_request(r);
            end
        end
        wait_for_idle();
    endtask

    initial
    begin
        for (int i = 0; i < SLOT_TOTAL; i++)
            slot_kind[i] = KIND_EMPTY;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_instance_load();
        test_condition_kinds();
        test_feature_count_extremes();
        test_random_traffic(6'd32, 30, 1'b1);
        test_random_traffic(6'($urandom_range(2, 31)), 25, 1'b1);
        test_random_traffic(6'd0, 6, 1'b1);
        test_random_traffic(6'd40, 20, 1'b1);
        test_random_traffic(6'd32, 30, 1'b0);

        repeat (30) @(posedge clk);
        $display("requests: %0d loads, %0d attribute writes, %0d evaluates, %0d dropped codes",
                 load_count, write_count, eval_count, other_count);
        $display("%0d feature results checked over feature counts 0, 1, 32 and saturated",
                 results_checked);
        if (mismatch_count == 0 && expected_bits_q.size() == 0)
            $display("conjunctive_feature_evaluator_unit: match");
        else
            $display("conjunctive_feature_evaluator_unit: mismatch");
        $finish;
    end

endmodule
